// ===== rtl/plce_pkg.sv =====
// Shared types and codes for the positional list engine.
`timescale 1ns / 1ps
package plce_pkg;

    // Widths that cover the largest supported list (256 entries)
    localparam int CNT_W = 9;
    localparam int IDX_W = 8;
    localparam int VAL_W = 32;

    // Operation codes
    localparam logic [2:0] KIND_INSERT = 3'd0;
    localparam logic [2:0] KIND_REMOVE = 3'd1;
    localparam logic [2:0] KIND_READ   = 3'd2;
    localparam logic [2:0] KIND_WRITE  = 3'd3;
    localparam logic [2:0] KIND_SEARCH = 3'd4;
    localparam logic [2:0] KIND_CLEAR  = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         position;
        logic signed [31:0] item_value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [3:0]         found_index;
        logic               found;
        logic [1:0]         status;
        logic [4:0]         count_now;
    } t_out;

    // Command broadcast to every cell on the accepting beat
    typedef struct packed {
        logic               load;
        logic               f_insert;
        logic               f_remove;
        logic               f_write;
        logic               f_pick;
        logic               f_search;
        logic [CNT_W-1:0]   target;
        logic [CNT_W-1:0]   limit;
        logic [VAL_W-1:0]   item;
    } t_cmd;

    // Hit token rippling down the chain
    typedef struct packed {
        logic               hit;
        logic [IDX_W-1:0]   idx;
        logic [VAL_W-1:0]   value;
    } t_carry;

endpackage

// ===== rtl/plce_cell.sv =====
// One list slot: holds an entry, shifts with its neighbours and passes the hit token on.
`timescale 1ns / 1ps
module plce_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  plce_pkg::t_cmd        i_cmd,
    input  logic [plce_pkg::CNT_W-1:0] i_cell_idx,
    input  logic [plce_pkg::VAL_W-1:0] i_left_val,
    input  logic [plce_pkg::VAL_W-1:0] i_right_val,
    input  plce_pkg::t_carry      i_carry,
    output logic [plce_pkg::VAL_W-1:0] o_val,
    output plce_pkg::t_carry      o_carry
);
    import plce_pkg::*;

    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] n_val;
    logic             r_tap_hit;
    logic             n_tap_hit;
    logic [VAL_W-1:0] r_tap_val;
    logic [VAL_W-1:0] n_tap_val;
    t_carry           r_carry;
    t_carry           n_carry;

    // Choose the new entry: open a gap, close a gap or overwrite
    always_comb begin
        n_val = r_val;
        if (i_cmd.load) begin
            if (i_cmd.f_insert && (i_cell_idx > i_cmd.target)) begin
                n_val = i_left_val;
            end else if (i_cmd.f_insert && (i_cell_idx == i_cmd.target)) begin
                n_val = i_cmd.item;
            end else if (i_cmd.f_remove && (i_cell_idx >= i_cmd.target)) begin
                n_val = i_right_val;
            end else if (i_cmd.f_write && (i_cell_idx == i_cmd.target)) begin
                n_val = i_cmd.item;
            end
        end
    end

    // Capture the pre-update entry and whether this slot answers the request
    always_comb begin
        n_tap_hit = r_tap_hit;
        n_tap_val = r_tap_val;
        if (i_cmd.load) begin
            n_tap_hit = (i_cmd.f_pick && (i_cell_idx == i_cmd.target))
                     || (i_cmd.f_search && (r_val == i_cmd.item)
                         && (i_cell_idx < i_cmd.limit));
            n_tap_val = r_val;
        end
    end

    // Keep the earliest hit; otherwise offer our own
    always_comb begin
        n_carry = i_carry;
        if (!i_carry.hit && r_tap_hit) begin
            n_carry.hit   = 1'b1;
            n_carry.idx   = IDX_W'(i_cell_idx);
            n_carry.value = r_tap_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val     <= n_val;
        r_tap_val <= n_tap_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_hit <= 1'b0;
            r_carry   <= '0;
        end else begin
            r_tap_hit <= n_tap_hit;
            r_carry   <= n_carry;
        end
    end

    assign o_val   = r_val;
    assign o_carry = r_carry;

endmodule

// ===== rtl/positional_list_engine_unit.sv =====
// Top level of the positional list engine: control, count and a chain of list cells.
// An accepted input beat yields a result beat once the hit token has rippled through every cell.
// Flow: one item at a time; the next input beat is taken the cycle after the
//   result beat is taken.
// The wait is set by the hit token rippling one cell per cycle down the chain.
// Reset (synchronous, active low) empties the list; entries hold no reset value.
`timescale 1ns / 1ps
module positional_list_engine_unit #(
    parameter int DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  plce_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output plce_pkg::t_out  o_out
);
    import plce_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CW-1:0]    r_wait;
    logic [CW-1:0]    n_wait;
    logic [1:0]       r_status;
    logic [1:0]       n_status;
    logic             r_is_pick;
    logic             r_is_search;
    t_out             r_out;
    t_out             n_out;

    logic             w_accept;
    logic             w_full;
    logic [CNT_W-1:0] w_cnt;
    logic [CNT_W-1:0] w_pos;
    t_cmd             w_cmd;

    logic [VAL_W-1:0] w_val   [DEPTH];
    t_carry           w_carry [DEPTH];

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_cnt      = CNT_W'(r_count);
    assign w_pos      = CNT_W'(i_in.position);

    // Decode the request into a broadcast command, status and new count
    always_comb begin
        w_cmd        = '0;
        w_cmd.load   = w_accept;
        w_cmd.item   = i_in.item_value;
        w_cmd.limit  = w_cnt;
        w_cmd.target = w_pos;
        n_status     = ST_OK;
        n_count      = r_count;
        case (i_in.kind)
            KIND_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_cmd.f_insert = 1'b1;
                    w_cmd.target   = (w_pos > w_cnt) ? w_cnt : w_pos;
                    n_count        = r_count + CW'(1);
                end
            end
            KIND_REMOVE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_cmd.f_remove = 1'b1;
                    w_cmd.f_pick   = 1'b1;
                    w_cmd.target   = (w_pos >= w_cnt) ? (w_cnt - CNT_W'(1)) : w_pos;
                    n_count        = r_count - CW'(1);
                end
            end
            KIND_READ: begin
                if (w_pos >= w_cnt) begin
                    n_status = ST_RANGE;
                end else begin
                    w_cmd.f_pick = 1'b1;
                end
            end
            KIND_WRITE: begin
                if (w_pos >= w_cnt) begin
                    n_status = ST_RANGE;
                end else begin
                    w_cmd.f_write = 1'b1;
                end
            end
            KIND_SEARCH: begin
                w_cmd.f_search = 1'b1;
            end
            KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Row of list cells; the token enters empty at the head
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            plce_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (w_cmd),
                .i_cell_idx  (CNT_W'(g)),
                .i_left_val  ((g == 0) ? w_val[g] : w_val[(g == 0) ? 0 : g - 1]),
                .i_right_val ((g == DEPTH - 1) ? w_val[g]
                                               : w_val[(g == DEPTH - 1) ? g : g + 1]),
                .i_carry     ((g == 0) ? t_carry'('0) : w_carry[(g == 0) ? 0 : g - 1]),
                .o_val       (w_val[g]),
                .o_carry     (w_carry[g])
            );
        end
    endgenerate

    // Sequence: wait for the token to leave the tail, then hold the result beat
    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        n_out   = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state         = S_RUN;
                    n_wait          = CW'(DEPTH);
                    n_out.count_now = 5'(n_count);
                end
            end
            S_RUN: begin
                if (r_wait == '0) begin
                    n_state            = S_OUT;
                    n_out.status       = r_status;
                    n_out.result_value = (r_is_pick && w_carry[DEPTH-1].hit)
                                       ? w_carry[DEPTH-1].value : '0;
                    n_out.found        = r_is_search && w_carry[DEPTH-1].hit;
                    n_out.found_index  = (r_is_search && w_carry[DEPTH-1].hit)
                                       ? 4'(w_carry[DEPTH-1].idx) : 4'd0;
                end else begin
                    n_wait = r_wait - CW'(1);
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wait <= n_wait;
        r_out  <= n_out;
        if (w_accept) begin
            r_status    <= n_status;
            r_is_pick   <= w_cmd.f_pick;
            r_is_search <= w_cmd.f_search;
        end
    end

    assign o_out_valid = (r_state == S_OUT);
    assign o_out       = r_out;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.kind == KIND_INSERT) && !w_full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

    a_found_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.found) |-> r_is_search)
        else $error("found flagged on a non-search beat");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("input taken while an item is in flight");

endmodule

// ===== tb/sv/plce_reply_checker.sv =====
// Reply checker for the positional list engine: tracks the list and checks every result beat.
`timescale 1ns / 1ps
module plce_reply_checker #(
    parameter int DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  plce_pkg::t_in   i_in,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  plce_pkg::t_out  i_out,
    output int              o_pending,
    output int              o_mismatch_count
);
    import plce_pkg::*;

    logic [31:0] shadow_list [DEPTH];
    int unsigned shadow_count;
    t_out        replies_due [$];
    int          mismatch_count;

    // Apply one operation to the shadow list and work out its reply
    function automatic t_out apply_list_op(t_in req);
        t_out        r;
        int unsigned pos;
        int unsigned i;
        r   = '0;
        pos = req.position;
        case (req.kind)
            KIND_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (pos > shadow_count)
                        pos = shadow_count;
                    for (i = shadow_count; i > pos; i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[pos] = req.item_value;
                    shadow_count++;
                end
            end
            KIND_REMOVE: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (pos > shadow_count - 1)
                        pos = shadow_count - 1;
                    r.result_value = shadow_list[pos];
                    for (i = pos; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i + 1];
                    shadow_count--;
                end
            end
            KIND_READ: begin
                if (pos >= shadow_count)
                    r.status = ST_RANGE;
                else
                    r.result_value = shadow_list[pos];
            end
            KIND_WRITE: begin
                if (pos >= shadow_count)
                    r.status = ST_RANGE;
                else
                    shadow_list[pos] = req.item_value;
            end
            KIND_SEARCH: begin
                for (i = 0; i < shadow_count && !r.found; i++) begin
                    if (shadow_list[i] == req.item_value) begin
                        r.found       = 1'b1;
                        r.found_index = 4'(i);
                    end
                end
            end
            KIND_CLEAR: begin
                shadow_count = 0;
            end
            default: begin
            end
        endcase
        r.count_now = 5'(shadow_count);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Check the result beat against the oldest reply, then log the input beat
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            shadow_count = 0;
            replies_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: result beat with no reply due, expected none, actual %p",
                             $time, i_out);
                    mismatch_count++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("result_value", want.result_value, i_out.result_value);
                    check_field("found_index", want.found_index, i_out.found_index);
                    check_field("found", want.found, i_out.found);
                    check_field("status", want.status, i_out.status);
                    check_field("count_now", want.count_now, i_out.count_now);
                end
            end
            if (i_in_valid && i_in_ready)
                replies_due.push_back(apply_list_op(i_in));
        end
        o_pending        <= replies_due.size();
        o_mismatch_count <= mismatch_count;
    end

endmodule

// ===== tb/sv/positional_list_engine_unit_tb.sv =====
// Testbench top for the positional list engine: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module positional_list_engine_unit_tb;
    import plce_pkg::*;

    localparam int DEPTH       = 16;
    localparam int ITEMS       = 800;
    localparam int CALM_ITEMS  = 100;
    localparam int STALL_LIMIT = 400;

    // Unused kind codes: the block should leave the list alone
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_in_valid  = 1'b0;
    logic   i_out_ready = 1'b0;
    t_in    i_in        = '0;
    logic   o_in_ready;
    logic   o_out_valid;
    t_out   o_out;

    int          pending;
    int          mismatches;
    int          idle_cycles = 0;
    bit          calm        = 1'b0;
    int          gap_odds    = 3;
    logic [31:0] value_pool [16];
    int          pool_fill   = 0;
    int          pool_next   = 0;

    always #1 i_clk = ~i_clk;

    positional_list_engine_unit #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out(o_out)
    );

    plce_reply_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_ready(o_in_ready),
        .i_in(i_in),
        .i_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_out(o_out),
        .o_pending(pending),
        .o_mismatch_count(mismatches)
    );

    // Drive one operation beat, hold it until taken, then maybe idle a while
    task automatic send_op(logic [2:0] kind, logic [7:0] pos, logic [31:0] val);
        t_in beat;
        beat.kind       = kind;
        beat.position   = pos;
        beat.item_value = val;
        i_in_valid <= 1'b1;
        i_in       <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        if (kind == KIND_INSERT || kind == KIND_WRITE) begin
            value_pool[pool_next] = val;
            pool_next = (pool_next + 1) % 16;
            if (pool_fill < 16)
                pool_fill++;
        end
        if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // Favour values recently inserted or written so searches hit and duplicates occur
    function automatic logic [31:0] pick_value();
        int c;
        c = $urandom_range(0, 9);
        if (c < 4 && pool_fill > 0)
            return value_pool[$urandom_range(0, pool_fill - 1)];
        if (c == 4) begin
            case ($urandom_range(0, 3))
                0:       return 32'h0000_0000;
                1:       return 32'hFFFF_FFFF;
                2:       return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [7:0] pick_position();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, DEPTH + 1));
    endfunction

    // Issue one random operation, weighted towards insert or remove by phase
    task automatic random_op(int ins_w, int rem_w);
        int          r;
        int          s;
        logic [2:0]  kind;
        r = $urandom_range(0, 99);
        s = $urandom_range(0, 99);
        if (r < ins_w)
            kind = KIND_INSERT;
        else if (r < ins_w + rem_w)
            kind = KIND_REMOVE;
        else if (s < 30)
            kind = KIND_READ;
        else if (s < 55)
            kind = KIND_WRITE;
        else if (s < 90)
            kind = KIND_SEARCH;
        else if (s < 94)
            kind = KIND_CLEAR;
        else if (s < 97)
            kind = KIND_SPARE_A;
        else
            kind = KIND_SPARE_B;
        send_op(kind, pick_position(), pick_value());
    endtask

    // Result side back-pressure: random stalls, sometimes long clear runs
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            i_out_ready <= 1'b1;
            if (calm) begin
                @(posedge i_clk);
            end else begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(40, 120)) @(posedge i_clk);
                else
                    repeat ($urandom_range(1, 24)) @(posedge i_clk);
                if (!calm) begin
                    i_out_ready <= 1'b0;
                    repeat ($urandom_range(1, 11)) @(posedge i_clk);
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int phase;
        int i;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list: remove, read, write and search all refused or empty
        send_op(KIND_REMOVE, 8'd0, 32'h0);
        send_op(KIND_READ, 8'd0, 32'h0);
        send_op(KIND_WRITE, 8'd0, 32'h1234_5678);
        send_op(KIND_SEARCH, 8'd0, 32'h0);
        // Insert at the front, past the end and in the middle
        send_op(KIND_INSERT, 8'd0, 32'h7FFF_FFFF);
        send_op(KIND_INSERT, 8'd255, 32'h8000_0000);
        send_op(KIND_INSERT, 8'd0, 32'hFFFF_FFFF);
        send_op(KIND_INSERT, 8'd1, 32'h0000_0000);
        // Read and write inside and outside the list
        send_op(KIND_READ, 8'd3, 32'h0);
        send_op(KIND_READ, 8'd4, 32'h0);
        send_op(KIND_READ, 8'd255, 32'h0);
        send_op(KIND_WRITE, 8'd2, 32'h5A5A_5A5A);
        send_op(KIND_WRITE, 8'd200, 32'hA5A5_A5A5);
        // Search with and without a match, then the unused codes
        send_op(KIND_SEARCH, 8'd0, 32'h8000_0000);
        send_op(KIND_SEARCH, 8'd0, 32'd12345);
        send_op(KIND_SPARE_A, 8'd255, 32'hFFFF_FFFF);
        send_op(KIND_SPARE_B, 8'd0, 32'h0);
        // Remove past the tail, the head, the tail, the lone element, then from an empty list
        send_op(KIND_REMOVE, 8'd255, 32'h0);
        send_op(KIND_REMOVE, 8'd0, 32'h0);
        send_op(KIND_REMOVE, 8'd1, 32'h0);
        send_op(KIND_REMOVE, 8'd0, 32'h0);
        send_op(KIND_REMOVE, 8'd0, 32'h0);
        // Append into an empty list, clear, then read the cleared list
        send_op(KIND_INSERT, 8'd7, 32'h0F0F_0F0F);
        send_op(KIND_CLEAR, 8'd0, 32'h0);
        send_op(KIND_READ, 8'd0, 32'h0);

        // Fill to capacity, push past it, find the last entry
        for (i = 0; i < DEPTH; i++)
            send_op(KIND_INSERT, 8'd255, $urandom());
        send_op(KIND_INSERT, pick_position(), $urandom());
        send_op(KIND_INSERT, 8'd0, $urandom());
        send_op(KIND_SEARCH, 8'd0, value_pool[(pool_next + 13) % 16]);
        send_op(KIND_READ, 8'(DEPTH - 1), 32'h0);
        send_op(KIND_WRITE, 8'(DEPTH - 1), $urandom());
        send_op(KIND_REMOVE, 8'd255, 32'h0);

        // Random phases that swing the list between full and empty
        for (i = 0; i < ITEMS; i++) begin
            phase = (i / 80) % 5;
            gap_odds = (phase == 3) ? 0 : 3;
            if (i >= ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if (i % 200 == 100) begin
                // Hold off until every reply has come back
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            case (phase)
                0:       random_op(60, 10);
                1:       random_op(35, 35);
                2:       random_op(10, 60);
                3:       random_op(45, 25);
                default: random_op(25, 45);
            endcase
        end
        i_in_valid <= 1'b0;

        // Drain, then let the pipeline settle
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DEPTH + 4) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/plce_pkg.sv
rtl/plce_cell.sv
rtl/positional_list_engine_unit.sv
tb/sv/plce_reply_checker.sv
tb/sv/positional_list_engine_unit_tb.sv
